>>> hdl/uule_pkg.sv
package uule_pkg;

  localparam int CNT_W   = 6;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [6:0] SEQ_TOP    = 7'd122;
  localparam logic [6:0] SEQ_BOTTOM = 7'd97;
  localparam logic [6:0] CH_SPACE   = 7'd32;
  localparam logic [6:0] CH_NL      = 7'd10;

  localparam logic [2:0] CNT_ONE   = 3'd1;
  localparam logic [2:0] CNT_TWO   = 3'd2;
  localparam logic [2:0] CNT_THREE = 3'd3;
  localparam logic [2:0] CNT_FOUR  = 3'd4;

  // line command handed from front to back
  typedef struct packed {
    logic             flush;
    logic             bank;
    logic [CNT_W-1:0] n;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  function automatic logic [6:0] enc6(input logic [5:0] v);
    return {1'b0, v} + CH_SPACE;
  endfunction

endpackage

>>> hdl/uule_fifo.sv
module uule_fifo
  import uule_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule

>>> hdl/uule_front.sv
module uule_front
  import uule_pkg::*;
#(
  parameter int LINE_BYTES = 45
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] data_byte,
  output wr_t        wr,
  output logic       push,
  output cmd_t       cmd,
  input  logic       q_full,
  input  done_t      done
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_inc;
  logic             wbank;
  logic [1:0]       busy;
  logic [1:0]       busy_next;
  logic             accept;
  logic             line_full;
  logic             hands_off;

  assign in_ready  = !q_full && !busy[wbank];
  assign accept    = in_valid && in_ready;
  assign fill_inc  = fill + 1'b1;
  assign line_full = (fill_inc == CNT_W'(LINE_BYTES));

  assign wr.en   = accept && (op == OP_DATA);
  assign wr.bank = wbank;
  assign wr.idx  = fill;
  assign wr.data = data_byte;

  assign push      = accept && ((op == OP_FLUSH) || line_full);
  assign cmd.flush = (op == OP_FLUSH);
  assign cmd.bank  = wbank;
  assign cmd.n     = (op == OP_FLUSH) ? fill : CNT_W'(LINE_BYTES);

  // bank goes to the back end whenever a command carries line bytes
  assign hands_off = push && ((op == OP_DATA) || (fill != '0));

  always_comb begin
    busy_next = busy;
    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (hands_off) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      wbank <= 1'b0;
      busy  <= '0;
    end else begin
      busy <= busy_next;
      if (accept) begin
        if (op == OP_FLUSH || line_full) begin
          fill <= '0;
        end else begin
          fill <= fill_inc;
        end
      end
      if (hands_off) begin
        wbank <= !wbank;
      end
    end
  end

endmodule

>>> hdl/uule_back.sv
module uule_back
  import uule_pkg::*;
#(
  parameter int LINE_BYTES = 45
) (
  input  logic       clk,
  input  logic       rst,
  input  wr_t        wr,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       pop,
  output done_t      done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_a,
  output logic [6:0] char_b,
  output logic [6:0] char_c,
  output logic [6:0] char_d,
  output logic [2:0] char_count,
  output logic       last
);

  localparam int DEPTH  = 2 * LINE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_RD,
    S_GRP,
    S_SEQ,
    S_EMPTY
  } state_t;

  state_t           state;
  cmd_t             cur;
  logic [CNT_W-1:0] pos;
  logic [1:0]       j;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [7:0]       b2;
  logic [6:0]       seq;
  logic             ofree;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata;
  logic             rvld;
  logic             rd_en;
  logic [CNT_W:0]   rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W:0]   pos_adv;
  logic [7:0]       cap;

  assign ofree   = !out_valid || out_ready;
  assign pop     = (state == S_IDLE) && !q_empty;
  assign rd_idx  = {1'b0, pos} + {{(CNT_W - 1){1'b0}}, j};
  assign rd_en   = (state == S_RD) && (j != 2'd3) && (rd_idx < {1'b0, cur.n});
  assign rd_addr = cur.bank ? ADDR_W'(LINE_BYTES) + ADDR_W'(rd_idx)
                            : ADDR_W'(rd_idx);
  assign wr_addr = wr.bank ? ADDR_W'(LINE_BYTES) + ADDR_W'(wr.idx)
                           : ADDR_W'(wr.idx);
  assign pos_adv = {1'b0, pos} + (CNT_W+1)'(3);
  // bytes past the fill count read as zero padding
  assign cap     = rvld ? rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      seq        <= SEQ_TOP;
      done.valid <= 1'b0;
      done.bank  <= 1'b0;
      rvld       <= 1'b0;
      pos        <= '0;
      j          <= '0;
    end else begin
      rvld       <= rd_en;
      done.valid <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= head;
            pos   <= '0;
            state <= (head.n != '0) ? S_LEN : S_EMPTY;
          end
        end
        S_LEN: begin
          if (ofree) begin
            out_valid  <= 1'b1;
            char_a     <= enc6(cur.n);
            char_b     <= '0;
            char_c     <= '0;
            char_d     <= '0;
            char_count <= CNT_ONE;
            last       <= 1'b0;
            j          <= '0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          // one read issued per cycle, captured the cycle after
          unique case (j)
            2'd1: b0 <= cap;
            2'd2: b1 <= cap;
            2'd3: b2 <= cap;
            default: ;
          endcase
          j <= j + 1'b1;
          if (j == 2'd3) begin
            state <= S_GRP;
          end
        end
        S_GRP: begin
          if (ofree) begin
            out_valid  <= 1'b1;
            char_a     <= enc6(b0[7:2]);
            char_b     <= enc6({b0[1:0], b1[7:4]});
            char_c     <= enc6({b1[3:0], b2[7:6]});
            char_d     <= enc6(b2[5:0]);
            char_count <= CNT_FOUR;
            last       <= 1'b0;
            if (pos_adv < {1'b0, cur.n}) begin
              pos   <= pos_adv[CNT_W-1:0];
              j     <= '0;
              state <= S_RD;
            end else begin
              state <= S_SEQ;
            end
          end
        end
        S_SEQ: begin
          if (ofree) begin
            out_valid  <= 1'b1;
            char_a     <= seq;
            char_b     <= CH_NL;
            char_c     <= '0;
            char_d     <= '0;
            char_count <= CNT_TWO;
            last       <= !cur.flush;
            seq        <= (seq <= SEQ_BOTTOM || seq > SEQ_TOP) ? SEQ_TOP : seq - 1'b1;
            done.valid <= 1'b1;
            done.bank  <= cur.bank;
            state      <= cur.flush ? S_EMPTY : S_IDLE;
          end
        end
        S_EMPTY: begin
          if (ofree) begin
            out_valid  <= 1'b1;
            char_a     <= CH_SPACE;
            char_b     <= seq;
            char_c     <= CH_NL;
            char_d     <= '0;
            char_count <= CNT_THREE;
            last       <= 1'b1;
            seq        <= SEQ_TOP;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/uuencode_line_encoder_top.sv
// uuencode line encoder
// input channel: in_valid/in_ready with op (0 = data byte, 1 = end of stream)
// and data_byte. output channel: out_valid/out_ready, one beat carries up to
// four characters (char_a..char_d, char_count) and last marks the final beat
// caused by an input beat.
// data bytes are taken one per cycle while in_ready is high into one of two
// line banks; a byte that fills a line, or an end of stream, queues a line
// command for the back end, so the front keeps filling the other bank while
// a line drains. a full line gives 17 beats: the length character, one group
// per three bytes, then the sequence character with newline. the back end
// pops the command from the queue and registers the length beat. each group
// is paced by the single read port of the line memory (three byte reads,
// then the output load), so a 45-byte line drains as queue pop, length beat,
// 15 groups, sequence beat. end of stream adds the empty line beat and
// returns the sequence character to 'z'.
// reset is synchronous and clears the fill count, queue, bank flags and
// sequence character; no clearing pass runs. a stalled receiver holds the
// output register, the back end waits, and in_ready drops once the queue is
// full or the bank to be filled is still draining.
module uuencode_line_encoder_top
  import uule_pkg::*;
#(
  parameter int LINE_BYTES = 45
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] char_a,
  output logic [6:0] char_b,
  output logic [6:0] char_c,
  output logic [6:0] char_d,
  output logic [2:0] char_count,
  output logic       last
);

  wr_t   wr;
  cmd_t  cmd;
  cmd_t  head;
  done_t done;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  uule_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .data_byte(data_byte),
    .wr       (wr),
    .push     (push),
    .cmd      (cmd),
    .q_full   (q_full),
    .done     (done)
  );

  uule_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (cmd),
    .full (q_full),
    .pop  (pop),
    .dout (head),
    .empty(q_empty)
  );

  uule_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .done      (done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_a    (char_a),
    .char_b    (char_b),
    .char_c    (char_c),
    .char_d    (char_d),
    .char_count(char_count),
    .last      (last)
  );

endmodule

>>> sim/tb_uuencode_line_encoder_top.sv
module tb_uuencode_line_encoder_top;
  import uule_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_BYTES = 45;

  typedef struct {
    logic [6:0] char_a;
    logic [6:0] char_b;
    logic [6:0] char_c;
    logic [6:0] char_d;
    logic [2:0] char_count;
    logic       last;
  } uu_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = OP_DATA;
  logic [7:0] data_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] char_a;
  logic [6:0] char_b;
  logic [6:0] char_c;
  logic [6:0] char_d;
  logic [2:0] char_count;
  logic       last;

  // encoder state as seen from outside
  logic [7:0] line_bytes [LINE_BYTES];
  int         fill_level = 0;
  logic [6:0] seq_char = SEQ_TOP;
  uu_beat_t   pending_beats [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_len = 0;
  int hold_left = 0;

  uuencode_line_encoder_top #(.LINE_BYTES(LINE_BYTES)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_a     (char_a),
    .char_b     (char_b),
    .char_c     (char_c),
    .char_d     (char_d),
    .char_count (char_count),
    .last       (last)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] six_to_char(input logic [5:0] v);
    return {1'b0, v} + CH_SPACE;
  endfunction

  task automatic push_beat(input logic [6:0] a, input logic [6:0] b, input logic [6:0] c,
                           input logic [6:0] d, input logic [2:0] n);
    uu_beat_t beat;
    beat.char_a = a;
    beat.char_b = b;
    beat.char_c = c;
    beat.char_d = d;
    beat.char_count = n;
    beat.last = 1'b0;
    pending_beats.push_back(beat);
  endtask

  task automatic queue_line(input int n);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [5:0] len6;
    len6 = n[5:0];
    push_beat(six_to_char(len6), 7'd0, 7'd0, 7'd0, CNT_ONE);
    for (int i = 0; i < n; i += 3) begin
      b0 = line_bytes[i];
      // missing bytes of a short final group count as zero
      b1 = (i + 1 < n) ? line_bytes[i + 1] : 8'd0;
      b2 = (i + 2 < n) ? line_bytes[i + 2] : 8'd0;
      push_beat(six_to_char(b0[7:2]), six_to_char({b0[1:0], b1[7:4]}),
                six_to_char({b1[3:0], b2[7:6]}), six_to_char(b2[5:0]), CNT_FOUR);
    end
    push_beat(seq_char, CH_NL, 7'd0, 7'd0, CNT_TWO);
    if (seq_char <= SEQ_BOTTOM || seq_char > SEQ_TOP) begin
      seq_char = SEQ_TOP;
    end else begin
      seq_char = seq_char - 7'd1;
    end
  endtask

  task automatic encode_input_beat(input logic in_op, input logic [7:0] in_byte);
    int       prior;
    uu_beat_t tail;
    prior = pending_beats.size();
    if (in_op == OP_DATA) begin
      line_bytes[fill_level] = in_byte;
      fill_level++;
      if (fill_level >= LINE_BYTES) begin
        queue_line(fill_level);
        fill_level = 0;
      end
    end else begin
      if (fill_level > 0) begin
        queue_line(fill_level);
      end
      push_beat(CH_SPACE, seq_char, CH_NL, 7'd0, CNT_THREE);
      fill_level = 0;
      seq_char = SEQ_TOP;
    end
    if (pending_beats.size() > prior) begin
      tail = pending_beats.pop_back();
      tail.last = 1'b1;
      pending_beats.push_back(tail);
    end
  endtask

  // input beats are predicted before the output beat of the same edge is checked
  always @(posedge clk) begin
    uu_beat_t want;
    if (rst) begin
      fill_level = 0;
      seq_char = SEQ_TOP;
    end else begin
      if (in_valid && in_ready) begin
        encode_input_beat(op, data_byte);
      end
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          $error("unexpected result beat: char_a %0d char_count %0d", char_a, char_count);
          fail_count++;
        end else begin
          want = pending_beats.pop_front();
          if (char_a !== want.char_a) begin
            $error("char_a: expected %0d, actual %0d", want.char_a, char_a);
            fail_count++;
          end
          if (char_b !== want.char_b) begin
            $error("char_b: expected %0d, actual %0d", want.char_b, char_b);
            fail_count++;
          end
          if (char_c !== want.char_c) begin
            $error("char_c: expected %0d, actual %0d", want.char_c, char_c);
            fail_count++;
          end
          if (char_d !== want.char_d) begin
            $error("char_d: expected %0d, actual %0d", want.char_d, char_d);
            fail_count++;
          end
          if (char_count !== want.char_count) begin
            $error("char_count: expected %0d, actual %0d", want.char_count, char_count);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= hold_len;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_left > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_beat(input logic in_op, input logic [7:0] in_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= in_op;
    data_byte <= in_byte;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_bytes(input int count);
    for (int i = 0; i < count; i++) begin
      send_beat(OP_DATA, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_empty_flush();
    // data_byte is ignored on end of stream
    send_beat(OP_FLUSH, 8'hFF);
    send_beat(OP_FLUSH, 8'h00);
  endtask

  task automatic test_partial_groups();
    send_beat(OP_DATA, 8'h00);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_DATA, 8'h80);
    send_beat(OP_FLUSH, 8'h5A);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_FLUSH, 8'hA5);
    send_beat(OP_DATA, 8'h01);
    send_beat(OP_DATA, 8'hFE);
    send_beat(OP_FLUSH, 8'h00);
  endtask

  task automatic test_bit_patterns();
    send_beat(OP_DATA, 8'h55);
    send_beat(OP_DATA, 8'hAA);
    send_beat(OP_DATA, 8'h7F);
    send_beat(OP_DATA, 8'h80);
    send_beat(OP_DATA, 8'h3C);
    send_beat(OP_DATA, 8'hC3);
    send_beat(OP_DATA, 8'h0F);
    send_beat(OP_FLUSH, 8'hFF);
  endtask

  // streams of random length cut to the remaining count, most closed by a flush
  task automatic test_random_streams(input int items);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(5))
        0: len = LINE_BYTES;
        1: len = 2 * LINE_BYTES;
        2: len = $urandom_range(LINE_BYTES - 2, LINE_BYTES + 2);
        default: len = $urandom_range(0, 12);
      endcase
      if (len > items - sent) begin
        len = items - sent;
      end
      send_bytes(len);
      sent += len;
      if ($urandom_range(3) != 0) begin
        send_beat(OP_FLUSH, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_len <= 400;
    hold_req <= hold_req + 1;
    send_bytes(2 * LINE_BYTES + 1);
    send_beat(OP_FLUSH, 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 36;
    recv_stall_pct = 65;
    test_empty_flush();
    test_partial_groups();
    test_bit_patterns();
    test_random_streams(25);

    send_idle_pct = 65;
    recv_stall_pct = 36;
    test_random_streams(25);
    test_backpressure();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_streams(50);

    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
